// ===== rtl/lubr_pkg.sv =====
package lubr_pkg;

    // Default sizing of the core
    localparam int LUBR_MAX_LEN  = 65536;
    localparam int LUBR_ALPHABET = 256;

    // Fixed widths of the stream fields
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 17;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 40;

    typedef struct packed {
        logic             too_long;
        logic             string_done;
        logic [LEN_W-1:0] window_length;
        logic [LEN_W-1:0] best_length;
    } lubr_result_t;

endpackage

// ===== rtl/longest_unique_byte_run_core.sv =====
// Channel  Dir  tdata                                     tlast          tuser
// s_       in   [7:0] byte_value                          end_of_string  -
// m_       out  [16:0] best_length, [33:17] window_length string_done    too_long
//
// One byte per cycle sustained while m_tready allows; each byte passes the
// input and output registers. The last-position table sits in a registered-read
// RAM: the read issues on input accept, the update writes back as the byte
// leaves the input register; a forwarding register covers back-to-back repeats.
// Reset clears the window state and the per-value valid bits.
// A stalled result holds in the output register while one more byte enters.
module longest_unique_byte_run_core
    import lubr_pkg::*;
#(
    parameter int MAX_LEN  = LUBR_MAX_LEN,
    parameter int ALPHABET = LUBR_ALPHABET
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] byte_value
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [16:0] best_length, [33:17] window_length
    output logic                 m_tlast,
    output logic                 m_tuser    // [0] too_long
);

    localparam int SLOT_W  = $clog2(ALPHABET);
    localparam int LSP_W   = $clog2(MAX_LEN);
    localparam int N_BYTES = 1 << BYTE_W;

    logic              p_valid_reg, p_valid_next;
    logic [SLOT_W-1:0] p_slot_reg;
    logic              p_last_reg;
    logic              p_fire;
    logic              s_accept;

    logic [SLOT_W-1:0] in_slot;
    logic [SLOT_W-1:0] slot_lut [N_BYTES];

    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [LSP_W-1:0]  wr_data;
    logic [LSP_W-1:0]  rd_data;

    lubr_result_t      result;
    lubr_result_t      out_reg;
    logic              out_valid_reg, out_valid_next;

    // Byte value modulo the alphabet size, folded into a constant table
    for (genvar g = 0; g < N_BYTES; g++) begin : g_slot_lut
        assign slot_lut[g] = SLOT_W'(g % ALPHABET);
    end

    assign in_slot = slot_lut[s_tdata[BYTE_W-1:0]];

    assign p_fire   = p_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !p_valid_reg || p_fire;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        p_valid_next = p_valid_reg;
        if (s_accept) begin
            p_valid_next = 1'b1;
        end else if (p_fire) begin
            p_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (p_fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            p_valid_reg   <= p_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p_slot_reg <= in_slot;
            p_last_reg <= s_tlast;
        end
        if (p_fire) begin
            out_reg <= result;
        end
    end

    lubr_ram #(
        .WIDTH (LSP_W),
        .DEPTH (ALPHABET)
    ) u_last_pos (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (s_accept),
        .rd_addr (in_slot),
        .rd_data (rd_data)
    );

    lubr_track #(
        .MAX_LEN  (MAX_LEN),
        .ALPHABET (ALPHABET)
    ) u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (p_fire),
        .slot    (p_slot_reg),
        .last    (p_last_reg),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .result  (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - 2*LEN_W){1'b0}},
                       out_reg.window_length, out_reg.best_length};
    assign m_tlast  = out_reg.string_done;
    assign m_tuser  = out_reg.too_long;

    a_stall_holds_item: assert property (@(posedge aclk) disable iff (!aresetn)
        p_valid_reg && !p_fire |=> p_valid_reg && $stable(p_slot_reg)
            && $stable(p_last_reg))
        else $error("pipeline item lost while stalled");

    a_no_accept_on_full: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready && p_valid_reg |-> !s_tready)
        else $error("input taken with both stages full");

endmodule

// ===== rtl/lubr_ram.sv =====
module lubr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Read-first: a read at the written address returns the old word
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/lubr_track.sv =====
module lubr_track
    import lubr_pkg::*;
#(
    parameter int MAX_LEN  = LUBR_MAX_LEN,
    parameter int ALPHABET = LUBR_ALPHABET
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        fire,
    input  logic [$clog2(ALPHABET)-1:0] slot,
    input  logic                        last,
    input  logic [$clog2(MAX_LEN)-1:0]  rd_data,
    output logic                        wr_en,
    output logic [$clog2(ALPHABET)-1:0] wr_addr,
    output logic [$clog2(MAX_LEN)-1:0]  wr_data,
    output lubr_result_t                result
);

    localparam int SLOT_W = $clog2(ALPHABET);
    localparam int LSP_W  = $clog2(MAX_LEN);
    localparam int POS_W  = $clog2(MAX_LEN + 1);

    logic [POS_W-1:0]    ws_reg, ws_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [POS_W-1:0]    best_reg, best_next;
    logic                ovf_reg, ovf_next;
    logic [ALPHABET-1:0] valid_reg, valid_next;
    logic                fwd_ok_reg, fwd_ok_next;
    logic [SLOT_W-1:0]   fwd_slot_reg, fwd_slot_next;
    logic [LSP_W-1:0]    fwd_pos_reg, fwd_pos_next;

    logic               over;
    logic [LSP_W-1:0]   lsp;
    logic [POS_W-1:0]   lsp_ext;
    logic               hit;
    logic [POS_W-1:0]   ws_new;
    logic [POS_W-1:0]   wlen;
    logic [POS_W-1:0]   best_new;
    logic [POS_W+LEN_W-1:0] wlen_wide;
    logic [POS_W+LEN_W-1:0] best_wide;

    always_comb begin
        over = pos_reg >= POS_W'(MAX_LEN);
        // The table word, read when the byte was accepted, misses a write made at that same edge
        lsp = (fwd_ok_reg && fwd_slot_reg == slot) ? fwd_pos_reg : rd_data;
        lsp_ext = POS_W'(lsp);
        hit = valid_reg[slot] && (lsp_ext >= ws_reg);
        ws_new = hit ? lsp_ext + POS_W'(1) : ws_reg;
        if (over) begin
            wlen = pos_reg - ws_reg;
        end else begin
            wlen = pos_reg - ws_new + POS_W'(1);
        end
        best_new = (!over && wlen > best_reg) ? wlen : best_reg;

        wlen_wide = {{LEN_W{1'b0}}, wlen};
        best_wide = {{LEN_W{1'b0}}, best_new};
        result.best_length   = best_wide[LEN_W-1:0];
        result.window_length = wlen_wide[LEN_W-1:0];
        result.string_done   = last;
        result.too_long      = ovf_reg || over;

        wr_en   = fire && !over;
        wr_addr = slot;
        wr_data = pos_reg[LSP_W-1:0];

        ws_next       = ws_reg;
        pos_next      = pos_reg;
        best_next     = best_reg;
        ovf_next      = ovf_reg;
        valid_next    = valid_reg;
        fwd_ok_next   = fwd_ok_reg;
        fwd_slot_next = fwd_slot_reg;
        fwd_pos_next  = fwd_pos_reg;

        if (fire) begin
            if (last) begin
                // Close the string: drop all per-string state
                ws_next    = '0;
                pos_next   = '0;
                best_next  = '0;
                ovf_next   = 1'b0;
                valid_next = '0;
            end else if (over) begin
                ovf_next = 1'b1;
            end else begin
                ws_next         = ws_new;
                pos_next        = pos_reg + POS_W'(1);
                best_next       = best_new;
                valid_next[slot] = 1'b1;
            end
            if (!over) begin
                fwd_ok_next   = 1'b1;
                fwd_slot_next = slot;
                fwd_pos_next  = pos_reg[LSP_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ws_reg     <= '0;
            pos_reg    <= '0;
            best_reg   <= '0;
            ovf_reg    <= 1'b0;
            valid_reg  <= '0;
            fwd_ok_reg <= 1'b0;
        end else begin
            ws_reg     <= ws_next;
            pos_reg    <= pos_next;
            best_reg   <= best_next;
            ovf_reg    <= ovf_next;
            valid_reg  <= valid_next;
            fwd_ok_reg <= fwd_ok_next;
        end
    end

    always_ff @(posedge aclk) begin
        fwd_slot_reg <= fwd_slot_next;
        fwd_pos_reg  <= fwd_pos_next;
    end

    a_ws_le_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        ws_reg <= pos_reg)
        else $error("window start past position");

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_W'(MAX_LEN))
        else $error("position past length limit");

    a_wlen_le_best: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |-> wlen <= best_new)
        else $error("window longer than best");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && last |=> pos_reg == '0 && valid_reg == '0 && !ovf_reg)
        else $error("string state not cleared at end");

endmodule
